FILE: hw/rtl/rcsf_pkg.sv
// Shared types, constants and pixel shading functions of the retro chroma shift filter.
`default_nettype none

package rcsf_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColW   = 12;
  localparam int unsigned WidthW = 13;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [WidthW-1:0] WidthReset = 13'd640;
  localparam logic [WidthW-1:0] WidthMin   = 13'd3;
  localparam logic [WidthW-1:0] WidthMax   = 13'd4096;
  localparam logic [ColW-1:0]   ShiftCols  = 12'd2;

  localparam logic [ChanW-1:0] RbMask = 8'hF8;
  localparam logic [ChanW-1:0] GMask  = 8'hFC;

  localparam logic [1:0] SubFirst = 2'd0;
  localparam logic [1:0] SubMid   = 2'd1;
  localparam logic [1:0] SubLast  = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pix_t;

  typedef struct packed {
    logic last;
    pix_t res2;
    pix_t res1;
    pix_t res0;
  } job_t;

  function automatic logic [ChanW-1:0] darken(input logic [ChanW-1:0] v, input logic odd);
    logic [ChanW+1:0] t;
    t = {2'b00, v} + {1'b0, v, 1'b0};
    return odd ? t[ChanW+1:2] : v;
  endfunction

  function automatic pix_t shade(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                                 input logic [ChanW-1:0] b, input logic odd);
    pix_t p;
    p.red   = darken(r & RbMask, odd);
    p.green = darken(g & GMask, odd);
    p.blue  = darken(b & RbMask, odd);
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rcsf_front.sv
// Front end: tracks row position and pixel history and builds the shaded results of each item.
`default_nettype none

module rcsf_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rcsf_pkg::WidthW-1:0] cfg_wdata_i,
  input  wire logic                        accept_i,
  input  wire rcsf_pkg::pix_t              pix_i,
  input  wire logic                        frame_start_i,
  output logic                             push_o,
  output rcsf_pkg::job_t                   job_o
);

  logic [rcsf_pkg::WidthW-1:0] width_q;
  logic [rcsf_pkg::WidthW-1:0] width_eff;
  logic [rcsf_pkg::WidthW-1:0] last_col;
  logic [rcsf_pkg::ColW-1:0]   col_q, col_d, cur;
  logic                        odd_q, odd_d, odd;
  logic                        last;
  rcsf_pkg::pix_t              hist_q [4];
  rcsf_pkg::pix_t              red0_src, red1_src;

  always_comb begin
    if (width_q < rcsf_pkg::WidthMin) begin
      width_eff = rcsf_pkg::WidthMin;
    end else if (width_q > rcsf_pkg::WidthMax) begin
      width_eff = rcsf_pkg::WidthMax;
    end else begin
      width_eff = width_q;
    end
    last_col = width_eff - 13'd1;

    cur  = frame_start_i ? '0 : col_q;
    odd  = frame_start_i ? 1'b0 : odd_q;
    last = {1'b0, cur} >= last_col;

    if (cur == 12'd2) begin
      red0_src = hist_q[1];
      red1_src = hist_q[1];
    end else if (cur == 12'd3) begin
      red0_src = hist_q[2];
      red1_src = hist_q[2];
    end else begin
      red0_src = hist_q[3];
      red1_src = hist_q[2];
    end

    job_o.last = last;
    job_o.res0 = rcsf_pkg::shade(red0_src.red, hist_q[1].green, pix_i.blue, odd);
    job_o.res1 = rcsf_pkg::shade(red1_src.red, hist_q[0].green, pix_i.blue, odd);
    job_o.res2 = rcsf_pkg::shade(hist_q[1].red, pix_i.green, pix_i.blue, odd);

    push_o = accept_i && (cur >= rcsf_pkg::ShiftCols);

    if (last) begin
      col_d = '0;
      odd_d = ~odd;
    end else begin
      col_d = cur + 12'd1;
      odd_d = odd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= rcsf_pkg::WidthReset;
      col_q   <= '0;
      odd_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        col_q <= col_d;
        odd_q <= odd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hist_q[3] <= hist_q[2];
      hist_q[2] <= hist_q[1];
      hist_q[1] <= hist_q[0];
      hist_q[0] <= pix_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rcsf_fifo.sv
// Short queue of result jobs between the front end and the output sequencer.
`default_nettype none

module rcsf_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rcsf_pkg::job_t job_i,
  input  wire logic           pop_i,
  output rcsf_pkg::job_t      job_o,
  output logic                empty_o,
  output logic                full_o
);

  rcsf_pkg::job_t                  mem_q [rcsf_pkg::QDepth];
  logic [rcsf_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [rcsf_pkg::QCntW-1:0]      cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == rcsf_pkg::QCntW'(rcsf_pkg::QDepth));
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("Queue popped while empty.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o || pop_i)
    else $error("Queue pushed while full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rcsf_pkg::QCntW'(rcsf_pkg::QDepth))
    else $error("Queue count beyond depth.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[rcsf_pkg::QPtrW-1:0])
    else $error("Queue pointers disagree with count.");

endmodule

`default_nettype wire

FILE: hw/rtl/rcsf_back.sv
// Back end: plays out the one or three results of each job through a registered output.
`default_nettype none

module rcsf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rcsf_pkg::job_t job_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output rcsf_pkg::pix_t      pix_o,
  output logic                row_end_o
);

  logic [1:0]     sub_q, sub_d;
  logic           valid_q, valid_d;
  rcsf_pkg::pix_t pix_q, sel;
  logic           row_end_q;
  logic           load, at_end;

  always_comb begin
    case (sub_q)
      rcsf_pkg::SubFirst: sel = job_i.res0;
      rcsf_pkg::SubMid:   sel = job_i.res1;
      default:            sel = job_i.res2;
    endcase
    load   = !empty_i && (!valid_q || ready_i);
    at_end = !job_i.last || (sub_q == rcsf_pkg::SubLast);
    pop_o  = load && at_end;
    sub_d  = sub_q;
    if (load) begin
      sub_d = at_end ? rcsf_pkg::SubFirst : sub_q + 2'd1;
    end
    valid_d = load ? 1'b1 : (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= rcsf_pkg::SubFirst;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pix_q     <= sel;
      row_end_q <= job_i.last && (sub_q == rcsf_pkg::SubLast);
    end
  end

  assign valid_o   = valid_q;
  assign pix_o     = pix_q;
  assign row_end_o = row_end_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q != rcsf_pkg::SubFirst) |-> !empty_i && job_i.last)
    else $error("Flush index active without a row-end job.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && job_i.last && sub_q == rcsf_pkg::SubMid) |=> sub_q == rcsf_pkg::SubLast)
    else $error("Flush sequence skipped a result.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) sub_q != 2'd3)
    else $error("Flush index out of range.");

endmodule

`default_nettype wire

FILE: hw/rtl/retro_chroma_shift_filter_top.sv
// Top level of the retro chroma shift filter: front end, job queue and output sequencer.
//
// Pixels enter on the slave stream in raster order, red in tdata[7:0], green in
// tdata[15:8] and blue in tdata[23:16]; tuser marks the first pixel of a frame.
// Processed pixels leave on the master stream in the same packing, with tlast on
// the last pixel of each row. Each output takes red from two columns left and blue
// from two columns right, clamped to the row, posterized and darkened on odd rows.
// The width register is written through cfg_we_i and cfg_wdata_i while idle.
// Output runs two pixels behind the input: the first two pixels of a row give no
// item, every later one gives one, and the last pixel of a row gives three.
// A result is written to the job queue when the pixel that causes it is accepted,
// then to the output register. The block takes one pixel per cycle while the queue
// has room; the four-entry job queue lets input go on while a row end plays out.
// Reset empties the queue and the output register, sets the row width to 640,
// and starts at column zero of an even row. When the receiver stalls, the output
// holds its item, the queue fills, and s_axis_tready falls once the queue is full.
`default_nettype none

module retro_chroma_shift_filter_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rcsf_pkg::WidthW-1:0] cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [23:0]                 s_axis_tdata,  // in_red, in_green, in_blue
  input  wire logic                        s_axis_tuser,  // frame_start
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [23:0]                      m_axis_tdata,  // out_red, out_green, out_blue
  output logic                             m_axis_tlast   // row_end
);

  logic           accept, push, pop, empty, full;
  rcsf_pkg::job_t job_in, job_out;
  rcsf_pkg::pix_t pix_out;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rcsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .pix_i         (rcsf_pkg::pix_t'(s_axis_tdata)),
    .frame_start_i (s_axis_tuser),
    .push_o        (push),
    .job_o         (job_in)
  );

  rcsf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty),
    .full_o  (full)
  );

  rcsf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (job_out),
    .empty_i   (empty),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .pix_o     (pix_out),
    .row_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = pix_out;

endmodule

`default_nettype wire

FILE: test/retro_chroma_shift_filter_top_tb.sv
// Self-checking testbench of the retro chroma shift filter top level.
`default_nettype none

module retro_chroma_shift_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit  = 2000;
  localparam int StallCycles = 64;
  localparam int TailCycles  = 4;

  typedef struct packed {
    logic           frame_start;
    rcsf_pkg::pix_t pix;
  } pixel_item_t;

  typedef struct packed {
    logic           row_end;
    rcsf_pkg::pix_t pix;
  } shaded_pixel_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_we_i      = 1'b0;
  logic [rcsf_pkg::WidthW-1:0] cfg_wdata_i   = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [23:0]                 s_axis_tdata  = '0;
  logic                        s_axis_tuser  = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [23:0]                 m_axis_tdata;
  logic                        m_axis_tlast;

  pixel_item_t   pending_pixels[$];
  shaded_pixel_t shaded_expect[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req     = 0;
  int stall_seen    = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;
  int errors        = 0;

  int             width_cfg = int'(rcsf_pkg::WidthReset);
  int             col_now   = 0;
  bit             odd_row   = 1'b0;
  rcsf_pkg::pix_t row_hist[4];

  retro_chroma_shift_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic logic [rcsf_pkg::ChanW-1:0] scan_dim(
      input logic [rcsf_pkg::ChanW-1:0] v, input bit odd);
    logic [rcsf_pkg::ChanW+1:0] prod;
    prod = 10'(v) * 10'd3;
    return odd ? prod[rcsf_pkg::ChanW+1:2] : v;
  endfunction

  function automatic rcsf_pkg::pix_t column_pixel(input int col, input int cur,
                                                  input rcsf_pkg::pix_t cur_pix);
    int back;
    back = cur - col;
    if (back == 0) begin
      return cur_pix;
    end
    return row_hist[back-1];
  endfunction

  task automatic predict_pixel(input pixel_item_t it);
    int             w;
    int             cur;
    int             shift;
    int             first;
    int             lastk;
    int             k;
    int             rcol;
    int             bcol;
    bit             at_end;
    rcsf_pkg::pix_t src_r;
    rcsf_pkg::pix_t src_g;
    rcsf_pkg::pix_t src_b;
    shaded_pixel_t  res;
    w = width_cfg;
    shift = int'(rcsf_pkg::ShiftCols);
    if (w < int'(rcsf_pkg::WidthMin)) begin
      w = int'(rcsf_pkg::WidthMin);
    end
    if (w > int'(rcsf_pkg::WidthMax)) begin
      w = int'(rcsf_pkg::WidthMax);
    end
    if (it.frame_start) begin
      col_now = 0;
      odd_row = 1'b0;
    end
    cur = col_now;
    at_end = cur >= w - 1;
    if (cur >= shift) begin
      first = cur - shift;
      lastk = at_end ? cur : first;
      for (k = first; k <= lastk; k++) begin
        rcol = (k >= shift) ? k - shift : 0;
        bcol = (k + shift > cur) ? cur : k + shift;
        src_r = column_pixel(rcol, cur, it.pix);
        src_g = column_pixel(k, cur, it.pix);
        src_b = column_pixel(bcol, cur, it.pix);
        res.pix.red   = scan_dim(src_r.red & rcsf_pkg::RbMask, odd_row);
        res.pix.green = scan_dim(src_g.green & rcsf_pkg::GMask, odd_row);
        res.pix.blue  = scan_dim(src_b.blue & rcsf_pkg::RbMask, odd_row);
        res.row_end   = at_end && (k == cur);
        shaded_expect.push_back(res);
      end
    end
    for (k = 3; k > 0; k--) begin
      row_hist[k] = row_hist[k-1];
    end
    row_hist[0] = it.pix;
    if (at_end) begin
      col_now = 0;
      odd_row = ~odd_row;
    end else begin
      col_now = cur + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pixel_item_t it;
        it = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.pix;
        s_axis_tuser  <= it.frame_start;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_seen != stall_req) begin
      stall_seen    <= stall_req;
      stall_left    <= StallCycles;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin : result_check
    shaded_pixel_t  want;
    rcsf_pkg::pix_t got;
    bit             moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pixel('{frame_start: s_axis_tuser, pix: s_axis_tdata});
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = m_axis_tdata;
        if (shaded_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected item tdata=%06h tlast=%0b",
                                    m_axis_tdata, m_axis_tlast));
        end else begin
          want = shaded_expect.pop_front();
          if (got.red != want.pix.red) begin
            report_mismatch($sformatf("red got %0d want %0d", got.red, want.pix.red));
          end
          if (got.green != want.pix.green) begin
            report_mismatch($sformatf("green got %0d want %0d", got.green, want.pix.green));
          end
          if (got.blue != want.pix.blue) begin
            report_mismatch($sformatf("blue got %0d want %0d", got.blue, want.pix.blue));
          end
          if (m_axis_tlast != want.row_end) begin
            report_mismatch($sformatf("row end got %0b want %0b", m_axis_tlast, want.row_end));
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
    end
    $display("retro_chroma_shift_filter_top test failed");
    $finish;
  end

  task automatic push_pixel(input int r, input int g, input int b, input bit fs);
    pixel_item_t it;
    it.frame_start = fs;
    it.pix.red     = r[7:0];
    it.pix.green   = g[7:0];
    it.pix.blue    = b[7:0];
    pending_pixels.push_back(it);
  endtask

  task automatic drain_all();
    do begin
      @(negedge clk_i);
    end while (pending_pixels.size() != 0 || s_axis_tvalid || shaded_expect.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_width(input int v);
    drain_all();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[rcsf_pkg::WidthW-1:0];
    width_cfg = v & ((1 << rcsf_pkg::WidthW) - 1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int pick_chan();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic push_random(input int n, input int fs_pct);
    int i;
    for (i = 0; i < n; i++) begin
      push_pixel(pick_chan(), pick_chan(), pick_chan(), $urandom_range(0, 99) < fs_pct);
    end
  endtask

  function automatic int pick_width();
    case ($urandom_range(0, 5))
      0:       return int'(rcsf_pkg::WidthMin);
      1:       return $urandom_range(0, (1 << rcsf_pkg::WidthW) - 1);
      default: return $urandom_range(3, 9);
    endcase
  endfunction

  initial begin
    int mode;
    int seg;
    send_idle_pct = 33;
    recv_idle_pct = 46;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h07, 8'h03, 8'h07, 1'b0);
    push_pixel(8'hF8, 8'hFC, 8'hF8, 1'b0);
    set_width((1 << rcsf_pkg::WidthW) - 1);
    push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    push_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    set_width(int'(rcsf_pkg::WidthMin));
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    push_pixel(8'hFE, 8'hFD, 8'hFB, 1'b1);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    set_width(0);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h01, 8'h02, 8'h04, 1'b0);
    push_pixel(8'h40, 8'h80, 8'hC0, 1'b0);
    set_width(int'(rcsf_pkg::WidthMax) + 1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    set_width(int'(rcsf_pkg::WidthMax));
    push_pixel(8'h9C, 8'h63, 8'hC9, 1'b0);
    set_width(4);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);

    for (mode = 0; mode < 3; mode++) begin
      drain_all();
      case (mode)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        set_width(pick_width());
        push_random(13, 4);
        if (mode == 2 && seg == 1) begin
          @(negedge clk_i);
          stall_req++;
          push_random(24, 0);
        end
      end
    end

    drain_all();
    repeat (10) @(posedge clk_i);
    if (shaded_expect.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", shaded_expect.size()));
    end
    if (errors == 0) begin
      $display("retro_chroma_shift_filter_top test passed");
    end else begin
      $display("retro_chroma_shift_filter_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
